// File: src/sha256_byte_stream_hasher_macros.svh
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS
`define SHABS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: same cycle implication");
`define SHABS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: next cycle implication");
`else
`define SHABS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHABS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/shabs_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher.
package shabs_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] shift_byte;
		logic       start;
		logic       reinit;
	} ctl_t;

	typedef struct packed {
		logic busy;
	} stat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LENGTH_AT = 6'd56;
	localparam logic [5:0] LAST_SLOT = 6'd63;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	localparam word_t K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic word_t bsig0(word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: src/sha256_byte_stream_hasher.sv
// Top level: byte intake, padding sequencer and digest output.
// The 64th byte of a block starts a compression (64 rounds, one fold) on the shared
// round unit, with s_tready low while it runs.
// End of message: 9 to 72 padding bytes go in one per cycle while the engine is not busy,
// around one or two more compressions, then four digest transfers.
// Reset (arst_n low, asynchronous) loads the initial hash and clears all counters.
`include "sha256_byte_stream_hasher_macros.svh"

module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] msg_byte
	input  logic        s_tuser,  // byte_present
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // [63:0] digest_word, [65:64] word_index, zero fill
	output logic        m_tlast   // last_word
);
	import shabs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PAD  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] total_q;
	logic        pad_first_q;
	logic        len_ok_q;
	logic [1:0]  idx_q;

	ctl_t        eng_ctl;
	stat_t       eng_status;
	hash_t       chain;

	logic        in_fire;
	logic        pad_fire;
	logic        out_fire;
	logic [5:0]  fill_nx;
	logic [63:0] bits_nx;
	logic [2:0]  sel;

	shabs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (eng_ctl),
		.status (eng_status),
		.chain  (chain)
	);

	assign s_tready = (state_q == S_IDLE) && !eng_status.busy;
	assign in_fire  = s_tvalid && s_tready;
	assign pad_fire = (state_q == S_PAD) && !eng_status.busy;
	assign m_tvalid = (state_q == S_OUT);
	assign out_fire = m_tvalid && m_tready;

	assign fill_nx = s_tuser ? fill_q + 6'd1 : fill_q;
	assign bits_nx = (s_tuser && fill_q == LAST_SLOT) ? bits_q + BLOCK_BITS : bits_q;

	always_comb begin
		eng_ctl = '0;
		if (in_fire && s_tuser) begin
			eng_ctl.shift      = 1'b1;
			eng_ctl.shift_byte = s_tdata;
			eng_ctl.start      = (fill_q == LAST_SLOT);
		end
		if (pad_fire) begin
			eng_ctl.shift = 1'b1;
			if (pad_first_q) begin
				eng_ctl.shift_byte = PAD_BYTE;
			end else if (len_ok_q && fill_q >= LENGTH_AT) begin
				eng_ctl.shift_byte = total_q[63:56];
			end else begin
				eng_ctl.shift_byte = 8'h00;
			end
			eng_ctl.start = (fill_q == LAST_SLOT);
		end
		eng_ctl.reinit = out_fire && m_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			idx_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						fill_q <= fill_nx;
						bits_q <= bits_nx;
						if (s_tlast) begin
							state_q     <= S_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				S_PAD: begin
					if (pad_fire) begin
						fill_q <= fill_q + 6'd1;
						if (pad_first_q) begin
							pad_first_q <= 1'b0;
							len_ok_q    <= (fill_q < LENGTH_AT) || (fill_q == LAST_SLOT);
						end else if (fill_q == LAST_SLOT) begin
							if (len_ok_q) begin
								state_q <= S_WAIT;
							end else begin
								len_ok_q <= 1'b1;
							end
						end
					end
				end
				S_WAIT: begin
					if (!eng_status.busy) begin
						state_q <= S_OUT;
						idx_q   <= '0;
					end
				end
				S_OUT: begin
					if (out_fire) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_q  <= S_IDLE;
							bits_q   <= '0;
							fill_q   <= '0;
							len_ok_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tlast) begin
			total_q <= bits_nx + {55'b0, fill_nx, 3'b000};
		end else if (pad_fire && !pad_first_q && len_ok_q && fill_q >= LENGTH_AT) begin
			total_q <= {total_q[55:0], 8'h00};
		end
	end

	assign sel     = {idx_q, 1'b0};
	assign m_tdata = {6'b0, idx_q, chain[sel], chain[sel + 3'd1]};
	assign m_tlast = (idx_q == 2'd3);

	`SHABS_ASSERT_IMP(a_ready_not_busy, clk, arst_n, s_tready, !eng_status.busy)
	`SHABS_ASSERT_IMP(a_start_when_free, clk, arst_n, eng_ctl.start, !eng_status.busy)
	`SHABS_ASSERT_IMP(a_out_not_busy, clk, arst_n, m_tvalid, !eng_status.busy)
	`SHABS_ASSERT_NXT(a_last_to_idle, clk, arst_n, out_fire && m_tlast, s_tready && fill_q == 6'd0)

endmodule

// File: src/shabs_round.sv
// One SHA-256 round plus one message schedule step.
module shabs_round (
	input  shabs_pkg::hash_t v,
	input  shabs_pkg::word_t k,
	input  shabs_pkg::word_t w_t16,
	input  shabs_pkg::word_t w_t15,
	input  shabs_pkg::word_t w_t7,
	input  shabs_pkg::word_t w_t2,
	output shabs_pkg::hash_t v_next,
	output shabs_pkg::word_t w_new
);
	import shabs_pkg::*;

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	assign ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
	assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
	assign t1 = v[7] + bsig1(v[4]) + ch + k + w_t16;
	assign t2 = bsig0(v[0]) + maj;

	always_comb begin
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

	assign w_new = w_t16 + ssig0(w_t15) + w_t7 + ssig1(w_t2);

endmodule

// File: src/shabs_engine.sv
// Block window, working variables, round counter and chaining words.
module shabs_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  shabs_pkg::ctl_t  ctl,
	output shabs_pkg::stat_t status,
	output shabs_pkg::hash_t chain
);
	import shabs_pkg::*;

	word_t      win_q [16];
	hash_t      v_q;
	hash_t      chain_q;
	logic [5:0] round_q;
	logic       run_q;
	logic       fin_q;
	hash_t      v_next;
	word_t      w_new;

	shabs_round u_round (
		.v      (v_q),
		.k      (K_TABLE[round_q]),
		.w_t16  (win_q[0]),
		.w_t15  (win_q[1]),
		.w_t7   (win_q[9]),
		.w_t2   (win_q[14]),
		.v_next (v_next),
		.w_new  (w_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			round_q <= '0;
			chain_q <= INIT_HASH;
		end else begin
			fin_q <= 1'b0;
			if (ctl.start) begin
				run_q   <= 1'b1;
				round_q <= '0;
			end else if (run_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == LAST_SLOT) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (ctl.reinit) begin
				chain_q <= INIT_HASH;
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= chain_q;
		end else if (run_q) begin
			v_q <= v_next;
		end
		if (run_q) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
		end else if (ctl.shift) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ctl.shift_byte};
		end
	end

	assign status.busy = run_q | fin_q;
	assign chain = chain_q;

endmodule
